[rtl/core/xcr_pkg.sv]
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types, constants and codes of the xmodem checksum receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

    // frame layout
    localparam int DATA_BYTES  = 128;
    localparam int FRAME_BYTES = DATA_BYTES + 4;
    localparam int FC_W        = $clog2(FRAME_BYTES);
    localparam int OFF_W       = 7;
    localparam int TMR_W       = 16;
    localparam int RTY_W       = 4;
    localparam int BLK_W       = 16;
    localparam int CFG_W       = 16;

    localparam logic [FC_W-1:0] FC_LAST = FC_W'(FRAME_BYTES - 1);

    // control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;

    // opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // frame verdicts
    localparam logic [1:0] VD_NONE    = 2'd0;
    localparam logic [1:0] VD_COMMIT  = 2'd1;
    localparam logic [1:0] VD_DISCARD = 2'd2;

    // register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    // reset values of the registers
    localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [RTY_W-1:0] RETRY_RST   = 4'd10;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic             reply_valid;
        logic [7:0]       reply_byte;
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [OFF_W-1:0] data_offset;
        logic [BLK_W-1:0] block_number;
        logic [1:0]       frame_verdict;
        logic [1:0]       status;
    } t_out_word;

    // input register toward the engine
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_in_stage;

    // engine result toward the output register
    typedef struct packed {
        logic      fire;
        t_out_word word;
    } t_result;

endpackage

[rtl/core/xcr_in_if.sv]
// ----------------------------------------------------------------------------
// xcr_in_if
// Input channel: opcode and received byte with valid/ready.
// ----------------------------------------------------------------------------
interface xcr_in_if import xcr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/xcr_out_if.sv]
// ----------------------------------------------------------------------------
// xcr_out_if
// Output channel: reply, tentative data and status with valid/ready.
// ----------------------------------------------------------------------------
interface xcr_out_if import xcr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/xcr_in_stage.sv]
// ----------------------------------------------------------------------------
// xcr_in_stage
// Input register: holds one word until the engine takes it.
// ----------------------------------------------------------------------------
module xcr_in_stage import xcr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xcr_in_if.sink       i_in,
    input  logic         i_take,
    output t_in_stage    o_stage
);

    logic     r_valid;
    t_in_word r_word;
    logic     pop;

    assign pop        = r_valid && i_take;
    assign i_in.ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word <= i_in.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

[rtl/core/xcr_engine.sv]
// ----------------------------------------------------------------------------
// xcr_engine
// Receiver state and per-word update: framing, checksum, timer and replies.
// ----------------------------------------------------------------------------
module xcr_engine import xcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_stage        i_stage,
    input  logic             i_take,
    output t_result          o_result
);

    // configuration
    logic [TMR_W-1:0] r_timeout;
    logic [RTY_W-1:0] r_retry_limit;

    // receiver state
    t_phase           r_phase,  n_phase;
    logic [FC_W-1:0]  r_count,  n_count;
    logic [BLK_W-1:0] r_block,  n_block;
    logic [RTY_W-1:0] r_retry,  n_retry;
    logic [TMR_W-1:0] r_timer,  n_timer;
    logic [7:0]       r_sum,    n_sum;
    logic             r_hdr_ok, n_hdr_ok;
    logic             r_eot,    n_eot;

    logic             fire;
    logic [1:0]       op;
    logic [7:0]       b;
    logic [FC_W-1:0]  off_full;
    logic [RTY_W-1:0] retry_inc;
    logic             retry_fail;
    logic [TMR_W-1:0] timer_inc;
    logic             clear;
    t_out_word        res;

    assign fire = i_stage.valid && i_take;
    assign op   = i_stage.word.opcode;
    assign b    = i_stage.word.rx_byte;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= TIMEOUT_RST;
            r_retry_limit <= RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout     <= i_cfg_wdata[TMR_W-1:0];
                CFG_RETRY:   r_retry_limit <= i_cfg_wdata[RTY_W-1:0];
                default:     r_timeout     <= r_timeout;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_block  <= BLK_W'(1);
            r_retry  <= '0;
            r_timer  <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b1;
            r_eot    <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_block  <= n_block;
            r_retry  <= n_retry;
            r_timer  <= n_timer;
            r_sum    <= n_sum;
            r_hdr_ok <= n_hdr_ok;
            r_eot    <= n_eot;
        end
    end

    // helpers: saturating retry step, saturating timer, payload offset
    assign retry_inc  = (r_retry != {RTY_W{1'b1}}) ? r_retry + RTY_W'(1) : r_retry;
    assign retry_fail = (retry_inc >= r_retry_limit);
    assign timer_inc  = (r_timer != {TMR_W{1'b1}}) ? r_timer + TMR_W'(1) : r_timer;
    assign off_full   = r_count - FC_W'(3);

    // next state and result
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_block  = r_block;
        n_retry  = r_retry;
        n_timer  = r_timer;
        n_sum    = r_sum;
        n_hdr_ok = r_hdr_ok;
        n_eot    = r_eot;
        clear    = 1'b0;
        res      = '0;

        case (op)
            OP_START: begin
                n_phase         = PH_RECV;
                n_block         = BLK_W'(1);
                n_retry         = '0;
                clear           = 1'b1;
                res.reply_valid = 1'b1;
                res.reply_byte  = CH_NAK;
            end
            OP_BYTE: begin
                if (r_phase == PH_RECV) begin
                    // header, payload or checksum by position
                    if (r_count == FC_W'(0)) begin
                        n_eot    = (b == CH_EOT);
                        n_hdr_ok = (b == CH_SOH);
                    end else if (r_count == FC_W'(1)) begin
                        n_hdr_ok = r_hdr_ok && (b == r_block[7:0]);
                    end else if (r_count == FC_W'(2)) begin
                        n_hdr_ok = r_hdr_ok && (b == ~r_block[7:0]);
                    end else if (r_count < FC_LAST) begin
                        n_sum           = r_sum + b;
                        res.data_valid  = 1'b1;
                        res.data_byte   = b;
                        res.data_offset = OFF_W'(off_full);
                    end
                    n_count = r_count + FC_W'(1);
                    // full frame: judge it
                    if (r_count >= FC_LAST) begin
                        res.reply_valid = 1'b1;
                        clear           = 1'b1;
                        if (!r_hdr_ok) begin
                            res.reply_byte    = CH_NAK;
                            res.frame_verdict = VD_DISCARD;
                        end else if (b != r_sum) begin
                            res.frame_verdict = VD_DISCARD;
                            n_retry           = retry_inc;
                            if (retry_fail) begin
                                n_phase        = PH_FAIL;
                                res.reply_byte = CH_CAN;
                            end else begin
                                res.reply_byte = CH_NAK;
                            end
                        end else begin
                            res.reply_byte    = CH_ACK;
                            res.frame_verdict = VD_COMMIT;
                            n_retry           = '0;
                            if (r_block != {BLK_W{1'b1}}) begin
                                n_block = r_block + BLK_W'(1);
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_RECV) begin
                    n_timer = timer_inc;
                    // reply timer ran out
                    if (timer_inc >= r_timeout) begin
                        res.reply_valid = 1'b1;
                        clear           = 1'b1;
                        if (r_count == FC_W'(1) && r_eot) begin
                            res.reply_byte = CH_ACK;
                            n_phase        = PH_DONE;
                        end else begin
                            if (r_count > FC_W'(3)) begin
                                res.frame_verdict = VD_DISCARD;
                            end
                            n_retry = retry_inc;
                            if (retry_fail) begin
                                n_phase        = PH_FAIL;
                                res.reply_byte = CH_CAN;
                            end else begin
                                res.reply_byte = CH_NAK;
                            end
                        end
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase

        // judgment, timeout or start clears the frame
        if (clear) begin
            n_count  = '0;
            n_sum    = '0;
            n_hdr_ok = 1'b1;
            n_eot    = 1'b0;
            n_timer  = '0;
        end

        res.status       = n_phase;
        res.block_number = (n_phase == PH_DONE) ? n_block - BLK_W'(1) : n_block;
    end

    assign o_result.fire = fire;
    assign o_result.word = res;

endmodule

[rtl/core/xcr_out_stage.sv]
// ----------------------------------------------------------------------------
// xcr_out_stage
// Result register: holds one word until the downstream side takes it.
// ----------------------------------------------------------------------------
module xcr_out_stage import xcr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result      i_result,
    output logic         o_take,
    xcr_out_if.source    o_out
);

    logic      r_valid;
    t_out_word r_word;

    // room when empty or when the held word leaves now
    assign o_take = !r_valid || o_out.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_result.fire;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_result.fire) begin
            r_word <= i_result.word;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;

endmodule

[rtl/core/xmodem_checksum_receiver.sv]
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// An accepted word passes the input register and the engine; its result word shows from the result register.
// Throughput: one word per cycle while the result channel is not stalled.
// The input and result registers let a word enter while a result waits.
// Reset (synchronous, active low): idle, block 1, timeout 1000, retry limit 10.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver import xcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    xcr_in_if.sink           i_in,
    xcr_out_if.source        o_out
);

    t_in_stage stage;
    t_result   result;
    logic      take;

    // input register
    xcr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    // state update
    xcr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (stage),
        .i_take      (take),
        .o_result    (result)
    );

    // result register
    xcr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_take   (take),
        .o_out    (o_out)
    );

endmodule

[rtl/core/xcr_checker.sv]
// ----------------------------------------------------------------------------
// xcr_checker
// Port-level checks on the result channel of the receiver.
// ----------------------------------------------------------------------------
module xcr_checker import xcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_ready,
    input  t_out_word i_word
);

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_word))
        else $error("result word changed while stalled");

    // commit only comes with an ack
    a_commit_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_word.frame_verdict == VD_COMMIT |->
            i_word.reply_valid && i_word.reply_byte == CH_ACK)
        else $error("commit without ack");

    // payload only streams while receiving and never with a reply
    a_data_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_word.data_valid |->
            !i_word.reply_valid && i_word.status == PH_RECV)
        else $error("payload byte outside receiving");

    // a failed transfer is reported with can
    a_fail_can: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_word.reply_valid && i_word.reply_byte == CH_CAN |->
            i_word.status == PH_FAIL)
        else $error("can without failure");

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_word  (o_out.data)
);
